>>> design/mlvr_pkg.sv
package mlvr_pkg;

  localparam int COLUMNS     = 120;
  localparam int PAGES       = 8;
  localparam int ROWS        = PAGES * 8;
  localparam int STORE_BYTES = COLUMNS * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam logic [1:0] REQ_POINT = 2'd0;
  localparam logic [1:0] REQ_LINE  = 2'd1;
  localparam logic [1:0] REQ_RECT  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [1:0] SEG_TOP    = 2'd0;
  localparam logic [1:0] SEG_LEFT   = 2'd1;
  localparam logic [1:0] SEG_RIGHT  = 2'd2;
  localparam logic [1:0] SEG_BOTTOM = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEG,
    S_FILLSET,
    S_RD,
    S_WR,
    S_RDATA
  } state_t;

  typedef enum logic [1:0] {
    PH_POINT,
    PH_SEG,
    PH_FILL
  } phase_t;

  function automatic logic [7:0] apply_mode(logic [7:0] data, logic [2:0] bitpos,
                                            logic [1:0] mode);
    logic [7:0] mask;
    mask = 8'(1) << bitpos;
    if (mode[1]) return data ^ mask;
    else if (mode[0]) return data | mask;
    else return data & ~mask;
  endfunction

endpackage

>>> design/mono_lcd_vector_raster.sv
// Monochrome raster store (120 x 64, one bit per pixel) with point, line,
// rectangle-with-fill and packed byte read requests. A request is taken when
// start is high and busy low; its result appears for one cycle with done. The
// store sits in one single-port RAM, so every pixel is read and then written
// back. Rejected requests answer in the cycle after they are taken. After
// reset the block clears the store with busy high. Results must be taken when
// shown.
module mono_lcd_vector_raster (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic [7:0] x_start,
  input  logic [6:0] y_start,
  input  logic [7:0] x_end,
  input  logic [6:0] y_end,
  input  logic [1:0] line_mode,
  input  logic [1:0] fill_mode,
  input  logic [2:0] page_index,
  output logic       done,
  output logic       status,
  output logic [7:0] read_data
);

  localparam int AW = mlvr_pkg::ADDR_W;

  mlvr_pkg::state_t state, state_next;
  mlvr_pkg::phase_t phase;

  logic [AW-1:0] clr_addr;
  logic [1:0] rtype, lmode, fmode, seg_idx;
  logic [7:0] xs, xe, fx;
  logic [6:0] ys, ye, fy;
  logic [7:0] sa_x, k, len, dmin, q, r;
  logic [6:0] sa_y;
  logic steep, neg_major, neg_minor;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  mlvr_ram #(.WIDTH(8), .DEPTH(mlvr_pkg::STORE_BYTES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // request checks
  logic xs_ok, xe_ok, ys_ok, ye_ok, pg_ok, rng_ok;
  assign xs_ok = {1'b0, x_start} < 9'(mlvr_pkg::COLUMNS);
  assign xe_ok = {1'b0, x_end} < 9'(mlvr_pkg::COLUMNS);
  assign ys_ok = {1'b0, y_start} < 8'(mlvr_pkg::ROWS);
  assign ye_ok = {1'b0, y_end} < 8'(mlvr_pkg::ROWS);
  assign pg_ok = {2'b0, page_index} < 5'(mlvr_pkg::PAGES);
  assign rng_ok = xs_ok && xe_ok && ys_ok && ye_ok;

  logic accept;
  assign busy = state != mlvr_pkg::S_IDLE;
  assign accept = start && !busy;

  logic req_ok;
  always_comb begin
    case (req_type)
      mlvr_pkg::REQ_POINT: req_ok = xs_ok && ys_ok;
      mlvr_pkg::REQ_READ:  req_ok = xe_ok && pg_ok;
      default:             req_ok = rng_ok;
    endcase
  end

  // segment endpoints
  logic [7:0] ax, bx;
  logic [6:0] ay, by;
  always_comb begin
    ax = xs; ay = ys; bx = xe; by = ye;
    if (rtype == mlvr_pkg::REQ_RECT) begin
      case (seg_idx)
        mlvr_pkg::SEG_TOP:   begin ax = xs; ay = ys; bx = xe; by = ys; end
        mlvr_pkg::SEG_LEFT:  begin ax = xs; ay = ys; bx = xs; by = ye; end
        mlvr_pkg::SEG_RIGHT: begin ax = xe; ay = ys; bx = xe; by = ye; end
        default:             begin ax = xs; ay = ye; bx = xe; by = ye; end
      endcase
    end
  end

  logic signed [8:0] dx, dy;
  logic [7:0] adx, ady, set_len;
  logic set_steep;
  assign dx = $signed({1'b0, bx}) - $signed({1'b0, ax});
  assign dy = $signed({2'b0, by}) - $signed({2'b0, ay});
  assign adx = dx[8] ? 8'(-dx) : dx[7:0];
  assign ady = dy[8] ? 8'(-dy) : dy[7:0];
  assign set_steep = ady > adx;
  assign set_len = set_steep ? ady : adx;

  logic seg_last;
  assign seg_last = (rtype == mlvr_pkg::REQ_LINE) || (seg_idx == mlvr_pkg::SEG_BOTTOM);

  // current pixel
  logic signed [8:0] off, mj, pc9, pr9;
  logic [7:0] pix_col;
  logic [6:0] pix_row;
  always_comb begin
    off = neg_minor ? -$signed({1'b0, q + 8'(r != 8'd0)}) : $signed({1'b0, q});
    mj  = neg_major ? -$signed({1'b0, k}) : $signed({1'b0, k});
    if (steep) begin
      pc9 = $signed({1'b0, sa_x}) + off;
      pr9 = $signed({2'b0, sa_y}) + mj;
    end else begin
      pc9 = $signed({1'b0, sa_x}) + mj;
      pr9 = $signed({2'b0, sa_y}) + off;
    end
    if (phase == mlvr_pkg::PH_SEG) begin
      pix_col = pc9[7:0];
      pix_row = pr9[6:0];
    end else begin
      pix_col = fx;
      pix_row = fy;
    end
  end

  logic [AW-1:0] pix_addr, rd_addr;
  assign pix_addr = AW'(pix_row[6:3]) * AW'(mlvr_pkg::COLUMNS) + AW'(pix_col);
  assign rd_addr  = AW'(page_index) * AW'(mlvr_pkg::COLUMNS) + AW'(x_end);

  // stepping
  logic [8:0] r_sum;
  logic seg_end, fill_has, fill_end, fy_wrap;
  assign r_sum = {1'b0, r} + {1'b0, dmin};
  assign seg_end = (k + 8'd1) == len;
  assign fill_has = ({1'b0, xe} > {1'b0, xs} + 9'd1) && ({1'b0, ye} > {1'b0, ys} + 8'd1);
  assign fy_wrap = fy == ye - 7'd1;
  assign fill_end = fy_wrap && (fx == xe - 8'd1);

  always_comb begin
    state_next = state;
    case (state)
      mlvr_pkg::S_CLEAR:
        if (clr_addr == AW'(mlvr_pkg::STORE_BYTES - 1)) state_next = mlvr_pkg::S_IDLE;
      mlvr_pkg::S_IDLE:
        if (accept && req_ok) begin
          case (req_type)
            mlvr_pkg::REQ_POINT: state_next = mlvr_pkg::S_RD;
            mlvr_pkg::REQ_READ:  state_next = mlvr_pkg::S_RDATA;
            default:             state_next = mlvr_pkg::S_SEG;
          endcase
        end
      mlvr_pkg::S_SEG:
        if (set_len != 8'd0) state_next = mlvr_pkg::S_RD;
        else if (seg_last) state_next = mlvr_pkg::S_FILLSET;
      mlvr_pkg::S_FILLSET:
        state_next = (rtype == mlvr_pkg::REQ_RECT && fill_has) ? mlvr_pkg::S_RD
                                                               : mlvr_pkg::S_IDLE;
      mlvr_pkg::S_RD: state_next = mlvr_pkg::S_WR;
      mlvr_pkg::S_WR:
        case (phase)
          mlvr_pkg::PH_SEG:
            if (!seg_end) state_next = mlvr_pkg::S_RD;
            else if (seg_last) state_next = mlvr_pkg::S_FILLSET;
            else state_next = mlvr_pkg::S_SEG;
          mlvr_pkg::PH_FILL:
            state_next = fill_end ? mlvr_pkg::S_IDLE : mlvr_pkg::S_RD;
          default: state_next = mlvr_pkg::S_IDLE;
        endcase
      mlvr_pkg::S_RDATA: state_next = mlvr_pkg::S_IDLE;
      default: state_next = mlvr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = mlvr_pkg::apply_mode(ram_rdata, pix_row[2:0],
                                     phase == mlvr_pkg::PH_FILL ? fmode : lmode);
    case (state)
      mlvr_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_addr;
        ram_wdata = 8'd0;
      end
      mlvr_pkg::S_IDLE: ram_addr = rd_addr;
      mlvr_pkg::S_WR: begin
        ram_we = 1'b1;
        ram_addr = pix_addr;
      end
      default: ram_addr = pix_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlvr_pkg::S_CLEAR;
      clr_addr <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (state == mlvr_pkg::S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state != mlvr_pkg::S_IDLE && state_next == mlvr_pkg::S_IDLE
          && state != mlvr_pkg::S_CLEAR)
        done <= 1'b1;
      if (accept && !req_ok) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mlvr_pkg::S_IDLE:
        if (accept) begin
          rtype <= req_type;
          xs <= x_start; ys <= y_start; xe <= x_end; ye <= y_end;
          lmode <= line_mode; fmode <= fill_mode;
          seg_idx <= mlvr_pkg::SEG_TOP;
          fx <= x_start; fy <= y_start;
          phase <= mlvr_pkg::PH_POINT;
          status <= !req_ok;
          read_data <= 8'd0;
        end
      mlvr_pkg::S_SEG: begin
        sa_x <= ax; sa_y <= ay;
        steep <= set_steep;
        len <= set_len;
        dmin <= set_steep ? adx : ady;
        neg_major <= set_steep ? dy[8] : dx[8];
        neg_minor <= set_steep ? dx[8] : dy[8];
        k <= 8'd0; q <= 8'd0; r <= 8'd0;
        phase <= mlvr_pkg::PH_SEG;
        if (set_len == 8'd0 && !seg_last) seg_idx <= seg_idx + 2'd1;
      end
      mlvr_pkg::S_FILLSET: begin
        fx <= xs + 8'd1;
        fy <= ys + 7'd1;
        phase <= mlvr_pkg::PH_FILL;
      end
      mlvr_pkg::S_WR:
        if (phase == mlvr_pkg::PH_SEG) begin
          k <= k + 8'd1;
          if (r_sum >= {1'b0, len}) begin
            r <= 8'(r_sum - {1'b0, len});
            q <= q + 8'd1;
          end else begin
            r <= r_sum[7:0];
          end
          if (seg_end && !seg_last) seg_idx <= seg_idx + 2'd1;
        end else if (phase == mlvr_pkg::PH_FILL) begin
          if (fy_wrap) begin
            fy <= ys + 7'd1;
            fx <= fx + 8'd1;
          end else begin
            fy <= fy + 7'd1;
          end
        end
      mlvr_pkg::S_RDATA: read_data <= ram_rdata;
      default: ;
    endcase
  end

  a_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == mlvr_pkg::S_CLEAR || state == mlvr_pkg::S_WR))
    else $error("store written outside clear or write-back");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == mlvr_pkg::S_WR |-> $past(state) == mlvr_pkg::S_RD)
    else $error("write-back without preceding read");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> read_data == 8'd0)
    else $error("rejected request returned data");
  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mlvr_pkg::S_WR && phase == mlvr_pkg::PH_SEG) |-> k < len)
    else $error("segment step beyond length");

endmodule

>>> design/mlvr_ram.sv
module mlvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 960
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

>>> verif/mono_lcd_vector_raster_tb.sv
`timescale 1ns / 1ps

module mono_lcd_vector_raster_tb;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] req_type;
  logic [7:0] x_start;
  logic [6:0] y_start;
  logic [7:0] x_end;
  logic [6:0] y_end;
  logic [1:0] line_mode;
  logic [1:0] fill_mode;
  logic [2:0] page_index;
  logic       done;
  logic       status;
  logic [7:0] read_data;

  mono_lcd_vector_raster dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .x_start(x_start), .y_start(y_start),
    .x_end(x_end), .y_end(y_end), .line_mode(line_mode),
    .fill_mode(fill_mode), .page_index(page_index),
    .done(done), .status(status), .read_data(read_data)
  );

  typedef struct packed {
    logic [1:0] rtype;
    logic [7:0] xs;
    logic [6:0] ys;
    logic [7:0] xe;
    logic [6:0] ye;
    logic [1:0] lm;
    logic [1:0] fm;
    logic [2:0] pg;
  } request_t;

  typedef struct packed {
    logic       st;
    logic [7:0] rd;
  } answer_t;

  typedef struct {
    request_t req;
    logic     typed;
    answer_t  ans;
  } stim_row_t;

  logic [7:0] panel [mlvr_pkg::STORE_BYTES];
  answer_t    answers_due[$];
  int         mismatches;
  int         cycles;
  int         idle_pct;
  stim_row_t  stim_rows[$];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    cycles = 0;
    wait (cycles > 20000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report(string what, answer_t got, answer_t want);
    $display("mismatch %s: status %0d/%0d data %02h/%02h at cycle %0d",
             what, got.st, want.st, got.rd, want.rd, cycles);
    mismatches++;
  endtask

  function automatic void plot(int col, int row, logic [1:0] mode);
    int idx;
    logic [7:0] bitmask;
    if (col < 0 || col >= mlvr_pkg::COLUMNS || row < 0 || row >= mlvr_pkg::ROWS) return;
    idx = (row >> 3) * mlvr_pkg::COLUMNS + col;
    bitmask = 8'(1) << (row & 7);
    if (mode[1]) panel[idx] ^= bitmask;
    else if (mode[0]) panel[idx] |= bitmask;
    else panel[idx] &= ~bitmask;
  endfunction

  function automatic int fdiv(int num, int den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic void trace_line(int x1, int y1, int x2, int y2, logic [1:0] mode);
    int dx, dy, adx, ady, sx, sy;
    dx = x2 - x1; dy = y2 - y1;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    sx = dx < 0 ? -1 : 1;
    sy = dy < 0 ? -1 : 1;
    if (adx >= ady) begin
      for (int k = 0; k < adx; k++) plot(x1 + sx * k, y1 + fdiv(dy * k, adx), mode);
    end else begin
      for (int k = 0; k < ady; k++) plot(x1 + fdiv(dx * k, ady), y1 + sy * k, mode);
    end
  endfunction

  function automatic answer_t raster_outcome(request_t r);
    answer_t a;
    bit in_panel;
    a = '0;
    in_panel = r.xs < mlvr_pkg::COLUMNS && r.xe < mlvr_pkg::COLUMNS &&
               r.ys < mlvr_pkg::ROWS && r.ye < mlvr_pkg::ROWS;
    case (r.rtype)
      mlvr_pkg::REQ_POINT: begin
        if (r.xs < mlvr_pkg::COLUMNS && r.ys < mlvr_pkg::ROWS) plot(r.xs, r.ys, r.lm);
        else a.st = 1;
      end
      mlvr_pkg::REQ_LINE: begin
        if (!in_panel) a.st = 1;
        else trace_line(r.xs, r.ys, r.xe, r.ye, r.lm);
      end
      mlvr_pkg::REQ_RECT: begin
        if (!in_panel) a.st = 1;
        else begin
          trace_line(r.xs, r.ys, r.xe, r.ys, r.lm);
          trace_line(r.xs, r.ys, r.xs, r.ye, r.lm);
          trace_line(r.xe, r.ys, r.xe, r.ye, r.lm);
          trace_line(r.xs, r.ye, r.xe, r.ye, r.lm);
          for (int x = int'(r.xs) + 1; x < int'(r.xe); x++)
            for (int y = int'(r.ys) + 1; y < int'(r.ye); y++) plot(x, y, r.fm);
        end
      end
      default: begin
        if (r.xe < mlvr_pkg::COLUMNS && r.pg < mlvr_pkg::PAGES)
          a.rd = panel[int'(r.pg) * mlvr_pkg::COLUMNS + int'(r.xe)];
        else a.st = 1;
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && done) begin
      got = '{st: status, rd: read_data};
      if (answers_due.size() == 0) report("unexpected", got, '0);
      else begin
        want = answers_due.pop_front();
        if (got.st !== want.st) report("status", got, want);
        else if (got.rd !== want.rd) report("read_data", got, want);
      end
    end
  end

  function automatic request_t mk(logic [1:0] t, int xs, int ys, int xe, int ye,
                                  int lm, int fm, int pg);
    request_t r;
    r.rtype = t;
    r.xs = 8'(xs);
    r.ys = 7'(ys);
    r.xe = 8'(xe);
    r.ye = 7'(ye);
    r.lm = 2'(lm);
    r.fm = 2'(fm);
    r.pg = 3'(pg);
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    r = raw[$bits(request_t)-1:0];
    if ($urandom_range(0, 9) < 8) begin
      // mostly in-panel, and small rectangles to keep the run short
      r.xs = 8'($urandom_range(0, mlvr_pkg::COLUMNS - 1));
      r.ys = 7'($urandom_range(0, mlvr_pkg::ROWS - 1));
      r.xe = 8'($urandom_range(0, mlvr_pkg::COLUMNS - 1));
      r.ye = 7'($urandom_range(0, mlvr_pkg::ROWS - 1));
      r.pg = 3'($urandom_range(0, mlvr_pkg::PAGES - 1));
      if (r.rtype == mlvr_pkg::REQ_RECT && $urandom_range(0, 19) != 0) begin
        r.xe = 8'((int'(r.xs) + int'($urandom_range(0, 12))) % mlvr_pkg::COLUMNS);
        r.ye = 7'((int'(r.ys) + int'($urandom_range(0, 10))) % mlvr_pkg::ROWS);
      end
    end
    return r;
  endfunction

  // start stays high from one accepted request into the next unless the
  // sender idles; callers drop it before any pause
  task automatic issue(request_t r, logic typed, answer_t want);
    answer_t pred;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1;
    {req_type, x_start, y_start, x_end, y_end, line_mode, fill_mode, page_index} <= r;
    do @(posedge clk); while (busy);
    pred = raster_outcome(r);
    answers_due.push_back(typed ? want : pred);
  endtask

  initial begin
    answer_t ok, rej;
    ok = '0;
    rej = '{st: 1, rd: 8'h00};
    rst = 1; start = 0; mismatches = 0; idle_pct = 0;
    {req_type, x_start, y_start, x_end, y_end, line_mode, fill_mode, page_index} = '0;
    foreach (panel[i]) panel[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 0;

    stim_rows.push_back('{mk(mlvr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_READ, 0, 0, 119, 0, 0, 0, 7), 1, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_READ, 0, 0, 120, 0, 0, 0, 0), 1, rej});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_READ, 0, 0, 255, 0, 0, 0, 7), 1, rej});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_POINT, 0, 0, 0, 0, 1, 0, 0), 1, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1,
                          '{st: 0, rd: 8'h01}});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_POINT, 119, 63, 0, 0, 3, 0, 0), 1, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_READ, 0, 0, 119, 0, 0, 0, 7), 1,
                          '{st: 0, rd: 8'h80}});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_POINT, 120, 0, 0, 0, 1, 0, 0), 1, rej});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_POINT, 0, 64, 0, 0, 1, 0, 0), 1, rej});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_POINT, 255, 127, 255, 127, 3, 3, 7), 1, rej});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_LINE, 0, 0, 120, 0, 1, 0, 0), 1, rej});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_RECT, 0, 0, 10, 127, 1, 1, 0), 1, rej});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_LINE, 5, 5, 5, 5, 1, 0, 0), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_LINE, 0, 0, 119, 63, 1, 0, 0), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_LINE, 119, 0, 0, 63, 2, 0, 0), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_LINE, 3, 60, 7, 2, 3, 0, 0), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_LINE, 50, 10, 50, 0, 0, 0, 0), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_RECT, 10, 10, 20, 18, 2, 1, 0), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_RECT, 30, 20, 22, 12, 1, 3, 0), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_RECT, 40, 5, 41, 30, 2, 1, 0), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_RECT, 60, 9, 60, 9, 1, 0, 0), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_RECT, 12, 11, 18, 17, 0, 0, 0), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_READ, 0, 0, 15, 0, 0, 0, 1), 0, ok});
    stim_rows.push_back('{mk(mlvr_pkg::REQ_READ, 0, 0, 26, 0, 0, 0, 2), 0, ok});
    foreach (stim_rows[i]) issue(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].ans);

    for (int n = 0; n < 950; n++) begin
      case (n / 190)
        0: idle_pct = 0;
        1: idle_pct = 80;
        2: idle_pct = 14;
        3: idle_pct = 0;
        default: idle_pct = $urandom_range(0, 1) ? 80 : 0;
      endcase
      if (n == 400) begin
        // hold off until the block has answered everything
        start <= 0;
        @(posedge clk);
        while (answers_due.size() != 0) @(posedge clk);
      end
      issue(random_request(), 0, '0);
    end

    start <= 0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
